// ===== rtl/prj_pkg.sv =====
// Shared types, constants and helper functions of the pinhole projection block.
package prj_pkg;

  // Quotient bits kept by every divider; larger quotients saturate any result.
  localparam int QB = 34;
  // Signed width of the final arithmetic (quotient cap plus error headroom).
  localparam int WIDE = QB + 3;
  // Stages: input, magnitudes, products, divider (QB + 2), output.
  localparam int NSTG = QB + 6;
  localparam int DIV_FIRST = 3;

  localparam int TERM_N = 55;
  localparam int TERM_D = 32;
  localparam int JP_N = 40;
  localparam int JP_D = 32;
  localparam int JZ_N = 71;
  localparam int JZ_D = 63;

  typedef enum logic [1:0] {
    CFG_FOCAL_U  = 2'd0,
    CFG_FOCAL_V  = 2'd1,
    CFG_CENTER_U = 2'd2,
    CFG_CENTER_V = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    logic               xn;
    logic               yn;
    logic               zn;
    logic               zero;
    logic signed [23:0] mu;
    logic signed [23:0] mv;
  } side_t;

  typedef struct packed {
    logic [TERM_N-1:0] prod_x;
    logic [TERM_N-1:0] prod_y;
    logic [JP_N-1:0]   num_u;
    logic [JP_N-1:0]   num_v;
    logic [JZ_D-1:0]   zsq;
    logic [31:0]       zm;
    side_t             side;
  } front_t;

  typedef struct packed {
    logic [31:0] val;
    logic        hit;
  } sat_t;

  function automatic logic signed [WIDE-1:0] apply_sign(logic [QB:0] m, logic neg);
    logic signed [WIDE-1:0] v;
    v = signed'({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic sat_t sat32(logic signed [WIDE-1:0] v);
    sat_t s;
    if (v > WIDE'(64'sd2147483647)) begin
      s.val = 32'h7fff_ffff;
      s.hit = 1'b1;
    end else if (v < -WIDE'(64'sd2147483648)) begin
      s.val = 32'h8000_0000;
      s.hit = 1'b1;
    end else begin
      s.val = v[31:0];
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

// ===== rtl/prj_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with round-half-up output.
module prj_div #(
  parameter int N = prj_pkg::TERM_N,
  parameter int D = prj_pkg::TERM_D,
  parameter int Q = prj_pkg::QB
) (
  input  logic         clk,
  input  logic [Q+1:0] en,
  input  logic [N-1:0] n,
  input  logic [D-1:0] d,
  output logic [Q:0]   mag
);

  localparam int HW = N - Q;
  localparam int CW = (HW > D) ? HW : D;

  logic [D-1:0] r_s  [Q+1];
  logic [Q-1:0] nq_s [Q+1];
  logic [D-1:0] d_s  [Q+1];
  logic         ovf_s[Q+1];

  logic [CW-1:0] hi_ext;
  logic [CW-1:0] d_ext;
  logic          ovf0;

  assign hi_ext = CW'(n[N-1:Q]);
  assign d_ext  = CW'(d);
  // A quotient of 2^Q or more can only saturate, so it is flagged up front.
  assign ovf0   = hi_ext >= d_ext;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r_s[0]   <= ovf0 ? '0 : hi_ext[D-1:0];
      nq_s[0]  <= n[Q-1:0];
      d_s[0]   <= d;
      ovf_s[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= Q; k++) begin : g_step
    logic [D:0] trial;
    logic [D:0] diff;
    logic       ge;
    assign trial = {r_s[k-1], nq_s[k-1][Q-1]};
    assign diff  = trial - {1'b0, d_s[k-1]};
    assign ge    = trial >= {1'b0, d_s[k-1]};
    always_ff @(posedge clk) begin
      if (en[k]) begin
        r_s[k]   <= ge ? diff[D-1:0] : trial[D-1:0];
        nq_s[k]  <= {nq_s[k-1][Q-2:0], ge};
        d_s[k]   <= d_s[k-1];
        ovf_s[k] <= ovf_s[k-1];
      end
    end
  end

  logic       rnd;
  logic [Q:0] qr;

  assign rnd = {r_s[Q], 1'b0} >= {1'b0, d_s[Q]};
  assign qr  = {1'b0, nq_s[Q]} + (Q+1)'(rnd);

  always_ff @(posedge clk) begin
    if (en[Q+1]) begin
      mag <= ovf_s[Q] ? {1'b1, {Q{1'b0}}} : qr;
    end
  end

endmodule

// ===== rtl/prj_front.sv =====
// Front stages: sign and magnitude split, then the focal and depth products.
module prj_front (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic signed [31:0]  x,
  input  logic signed [31:0]  y,
  input  logic signed [31:0]  z,
  input  logic signed [23:0]  mu,
  input  logic signed [23:0]  mv,
  input  logic [23:0]         fu,
  input  logic [23:0]         fv,
  output prj_pkg::front_t     fr
);

  logic [31:0]     xm;
  logic [31:0]     ym;
  logic [31:0]     zm;
  prj_pkg::side_t  side1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xm         <= x[31] ? (~x + 32'd1) : x;
      ym         <= y[31] ? (~y + 32'd1) : y;
      zm         <= z[31] ? (~z + 32'd1) : z;
      side1.xn   <= x[31];
      side1.yn   <= y[31];
      side1.zn   <= z[31];
      side1.zero <= z == 32'sd0;
      side1.mu   <= mu;
      side1.mv   <= mv;
    end
  end

  logic [55:0] px_full;
  logic [55:0] py_full;
  logic [63:0] zz_full;

  assign px_full = fu * xm;
  assign py_full = fv * ym;
  assign zz_full = zm * zm;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fr.prod_x <= px_full[prj_pkg::TERM_N-1:0];
      fr.prod_y <= py_full[prj_pkg::TERM_N-1:0];
      fr.zsq    <= zz_full[prj_pkg::JZ_D-1:0];
      fr.num_u  <= {fu, 16'b0};
      fr.num_v  <= {fv, 16'b0};
      fr.zm     <= zm;
      fr.side   <= side1;
    end
  end

endmodule

// ===== rtl/pinhole_reprojection_error_jacobian.sv =====
// Top level: pinhole projection with reprojection error and projection Jacobian.
//
// Input words (point_x/y/z in Q16.16, meas_u/v in Q16.8) arrive on a
// valid/ready channel; every word yields one result word of six Q24.8
// fields and a status code on a second valid/ready channel.
// Configuration (focal and center registers) is written through
// cfg_write/cfg_index/cfg_data and takes effect on the next word; write it
// only while no word is in flight.
// The pipeline has 40 register stages: input capture, sign split, the
// focal and depth multipliers, six parallel restoring dividers that retire
// one quotient bit per stage (34 bits plus init and rounding), and the
// output stage. One word can be accepted every cycle while in_ready is high.
// Each stage holds a valid bit; a stage advances when it is empty or the
// next one advances, so a stalled receiver holds the output word while
// earlier bubbles still fill, and in_ready drops only once every stage is
// full. Synchronous reset clears all valid bits and restores the focal
// lengths to 1.0 and the centers to 0; no clearing pass is needed.
module pinhole_reprojection_error_jacobian (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [23:0] meas_u,
  input  logic signed [23:0] meas_v,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] err_u,
  output logic signed [31:0] err_v,
  output logic signed [31:0] jac_u_by_x,
  output logic signed [31:0] jac_u_by_z,
  output logic signed [31:0] jac_v_by_y,
  output logic signed [31:0] jac_v_by_z,
  output logic [1:0]         status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int NS = prj_pkg::NSTG;
  localparam int DF = prj_pkg::DIV_FIRST;
  localparam int DL = DF + prj_pkg::QB + 1;

  logic [23:0] focal_u;
  logic [23:0] focal_v;
  logic [23:0] center_u;
  logic [23:0] center_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_u  <= 24'd256;
      focal_v  <= 24'd256;
      center_u <= 24'd0;
      center_v <= 24'd0;
    end else if (cfg_write) begin
      case (prj_pkg::cfg_index_t'(cfg_index))
        prj_pkg::CFG_FOCAL_U:  focal_u  <= cfg_data;
        prj_pkg::CFG_FOCAL_V:  focal_v  <= cfg_data;
        prj_pkg::CFG_CENTER_U: center_u <= cfg_data;
        prj_pkg::CFG_CENTER_V: center_v <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage control: a stage loads when it is empty or its successor moves.
  logic [NS-1:0] valid;
  logic [NS:0]   rdy;

  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !valid[k] || rdy[k+1];
  end
  assign in_ready  = rdy[0];
  assign out_valid = valid[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (rdy[0]) valid[0] <= in_valid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) valid[k] <= valid[k-1];
      end
    end
  end

  logic signed [31:0] x0;
  logic signed [31:0] y0;
  logic signed [31:0] z0;
  logic signed [23:0] mu0;
  logic signed [23:0] mv0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0  <= point_x;
      y0  <= point_y;
      z0  <= point_z;
      mu0 <= meas_u;
      mv0 <= meas_v;
    end
  end

  prj_pkg::front_t fr;

  prj_front u_front (
    .clk (clk),
    .en  (rdy[2:1]),
    .x   (x0),
    .y   (y0),
    .z   (z0),
    .mu  (mu0),
    .mv  (mv0),
    .fu  (focal_u),
    .fv  (focal_v),
    .fr  (fr)
  );

  logic [prj_pkg::QB:0] term_u_mag;
  logic [prj_pkg::QB:0] term_v_mag;
  logic [prj_pkg::QB:0] jp_u_mag;
  logic [prj_pkg::QB:0] jp_v_mag;
  logic [prj_pkg::QB:0] jz_u_mag;
  logic [prj_pkg::QB:0] jz_v_mag;

  prj_div #(.N(prj_pkg::TERM_N), .D(prj_pkg::TERM_D), .Q(prj_pkg::QB)) u_div_term_u (
    .clk (clk), .en (rdy[DL:DF]), .n (fr.prod_x), .d (fr.zm), .mag (term_u_mag)
  );
  prj_div #(.N(prj_pkg::TERM_N), .D(prj_pkg::TERM_D), .Q(prj_pkg::QB)) u_div_term_v (
    .clk (clk), .en (rdy[DL:DF]), .n (fr.prod_y), .d (fr.zm), .mag (term_v_mag)
  );
  prj_div #(.N(prj_pkg::JP_N), .D(prj_pkg::JP_D), .Q(prj_pkg::QB)) u_div_jp_u (
    .clk (clk), .en (rdy[DL:DF]), .n (fr.num_u), .d (fr.zm), .mag (jp_u_mag)
  );
  prj_div #(.N(prj_pkg::JP_N), .D(prj_pkg::JP_D), .Q(prj_pkg::QB)) u_div_jp_v (
    .clk (clk), .en (rdy[DL:DF]), .n (fr.num_v), .d (fr.zm), .mag (jp_v_mag)
  );
  prj_div #(.N(prj_pkg::JZ_N), .D(prj_pkg::JZ_D), .Q(prj_pkg::QB)) u_div_jz_u (
    .clk (clk), .en (rdy[DL:DF]), .n ({fr.prod_x, 16'b0}), .d (fr.zsq), .mag (jz_u_mag)
  );
  prj_div #(.N(prj_pkg::JZ_N), .D(prj_pkg::JZ_D), .Q(prj_pkg::QB)) u_div_jz_v (
    .clk (clk), .en (rdy[DL:DF]), .n ({fr.prod_y, 16'b0}), .d (fr.zsq), .mag (jz_v_mag)
  );

  // Signs, zero flag and measurements ride alongside the dividers.
  prj_pkg::side_t side_s [DF:DL];

  always_ff @(posedge clk) begin
    if (rdy[DF]) side_s[DF] <= fr.side;
    for (int k = DF + 1; k <= DL; k++) begin
      if (rdy[k]) side_s[k] <= side_s[k-1];
    end
  end

  prj_pkg::side_t sd;
  logic signed [prj_pkg::WIDE-1:0] mu_ext;
  logic signed [prj_pkg::WIDE-1:0] mv_ext;
  logic signed [prj_pkg::WIDE-1:0] cu_ext;
  logic signed [prj_pkg::WIDE-1:0] cv_ext;
  prj_pkg::sat_t s_eu, s_ev, s_jux, s_juz, s_jvy, s_jvz;

  assign sd     = side_s[DL];
  assign mu_ext = prj_pkg::WIDE'(sd.mu);
  assign mv_ext = prj_pkg::WIDE'(sd.mv);
  assign cu_ext = signed'({{(prj_pkg::WIDE-24){1'b0}}, center_u});
  assign cv_ext = signed'({{(prj_pkg::WIDE-24){1'b0}}, center_v});

  assign s_eu  = prj_pkg::sat32(mu_ext - cu_ext -
                                prj_pkg::apply_sign(term_u_mag, sd.xn ^ sd.zn));
  assign s_ev  = prj_pkg::sat32(mv_ext - cv_ext -
                                prj_pkg::apply_sign(term_v_mag, sd.yn ^ sd.zn));
  assign s_jux = prj_pkg::sat32(prj_pkg::apply_sign(jp_u_mag, sd.zn));
  assign s_jvy = prj_pkg::sat32(prj_pkg::apply_sign(jp_v_mag, sd.zn));
  assign s_juz = prj_pkg::sat32(prj_pkg::apply_sign(jz_u_mag, !sd.xn));
  assign s_jvz = prj_pkg::sat32(prj_pkg::apply_sign(jz_v_mag, !sd.yn));

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      if (sd.zero) begin
        err_u      <= '0;
        err_v      <= '0;
        jac_u_by_x <= '0;
        jac_u_by_z <= '0;
        jac_v_by_y <= '0;
        jac_v_by_z <= '0;
        status     <= prj_pkg::ST_ZERO;
      end else begin
        err_u      <= s_eu.val;
        err_v      <= s_ev.val;
        jac_u_by_x <= s_jux.val;
        jac_u_by_z <= s_juz.val;
        jac_v_by_y <= s_jvy.val;
        jac_v_by_z <= s_jvz.val;
        status     <= (s_eu.hit | s_ev.hit | s_jux.hit | s_juz.hit | s_jvy.hit | s_jvz.hit)
                      ? prj_pkg::ST_SAT : prj_pkg::ST_OK;
      end
    end
  end

  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> valid[0] && valid[NS-1])
    else $error("input blocked while the pipeline has room");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> valid[0])
    else $error("accepted word did not enter the first stage");

  a_output_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result word was dropped");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == prj_pkg::ST_ZERO |->
      err_u == 32'sd0 && jac_u_by_x == 32'sd0 && jac_v_by_z == 32'sd0)
    else $error("zero depth result carries nonzero fields");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench of the pinhole reprojection error and Jacobian block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] eu, ev, jux, juz, jvy, jvz;
    logic [1:0]  st;
  } proj_result_t;

  // Camera registers mirrored here and the queue of projections still to arrive.
  class proj_scoreboard;
    logic [23:0] fu, fv, cu, cv;
    proj_result_t pending[$];
    int mismatches;
    int checked;

    function new();
      fu = 24'd256; fv = 24'd256; cu = 24'd0; cv = 24'd0;
      mismatches = 0; checked = 0;
    endfunction

    // Rounded magnitude of num / den, ties away from zero, capped at 2^40.
    function automatic logic [127:0] rdiv(logic [127:0] num, logic [127:0] den);
      logic [127:0] q, r;
      q = num / den;
      r = num % den;
      if (2 * r >= den) q = q + 1;
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      return q;
    endfunction

    function automatic logic [31:0] clamp(logic signed [127:0] v, inout logic hit);
      if (v > 128'sd2147483647) begin
        hit = 1; return 32'h7fff_ffff;
      end
      if (v < -128'sd2147483648) begin
        hit = 1; return 32'h8000_0000;
      end
      return v[31:0];
    endfunction

    function automatic void project_axis(logic [23:0] f, logic [23:0] c,
        logic signed [31:0] p, logic signed [31:0] z, logic signed [23:0] m,
        inout logic hit, output logic [31:0] e, output logic [31:0] jp,
        output logic [31:0] jz);
      logic [127:0] pm, zm, prod, tq, pq, zq;
      logic signed [127:0] term, jpv, jzv;
      pm = p < 0 ? 128'(-64'(p)) : 128'(p);
      zm = z < 0 ? 128'(-64'(z)) : 128'(z);
      prod = 128'(f) * pm;
      tq = rdiv(prod, zm);
      pq = rdiv(128'(f) << 16, zm);
      zq = rdiv(prod << 16, zm * zm);
      term = ((p < 0) != (z < 0)) ? -$signed(tq) : $signed(tq);
      jpv = (z < 0) ? -$signed(pq) : $signed(pq);
      jzv = (p < 0) ? $signed(zq) : -$signed(zq);
      e = clamp(128'(m) - $signed(128'(c)) - term, hit);
      jp = clamp(jpv, hit);
      jz = clamp(jzv, hit);
    endfunction

    function void note_point(logic signed [31:0] x, y, z, logic signed [23:0] mu, mv);
      proj_result_t r;
      logic hit;
      hit = 0;
      if (z == 0) begin
        r = '{0, 0, 0, 0, 0, 0, prj_pkg::ST_ZERO};
      end else begin
        project_axis(fu, cu, x, z, mu, hit, r.eu, r.jux, r.juz);
        project_axis(fv, cv, y, z, mv, hit, r.ev, r.jvy, r.jvz);
        r.st = hit ? prj_pkg::ST_SAT : prj_pkg::ST_OK;
      end
      pending.push_back(r);
    endfunction

    function void check_result(proj_result_t got);
      proj_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_ready = 0, cfg_write = 0;
  logic in_ready, out_valid;
  logic signed [31:0] point_x = 0, point_y = 0, point_z = 0;
  logic signed [23:0] meas_u = 0, meas_v = 0;
  logic signed [31:0] err_u, err_v, jac_u_by_x, jac_u_by_z, jac_v_by_y, jac_v_by_z;
  logic [1:0] status;
  logic [1:0] cfg_index = prj_pkg::CFG_FOCAL_U;
  logic [23:0] cfg_data = 0;

  int send_idle = 0, recv_idle = 0, hold_off = 0;
  longint cycles = 0;
  proj_scoreboard board = new();

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  pinhole_reprojection_error_jacobian i_dut (.*);

  // Receiver with random stalls and an optional long hold-off.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready)
      board.check_result('{err_u, err_v, jac_u_by_x, jac_u_by_z, jac_v_by_y,
                           jac_v_by_z, status});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("timeout after %0d cycles", cycles);
      $display("** pinhole_reprojection_error_jacobian: FAILED **");
      $finish;
    end
  end

  // Valid stays high from one word to the next; it drops only while idling.
  task automatic send_point(logic signed [31:0] x, y, z, logic signed [23:0] mu, mv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    point_x <= x; point_y <= y; point_z <= z; meas_u <= mu; meas_v <= mv;
    do @(posedge clk); while (!in_ready);
    board.note_point(x, y, z, mu, mv);
  endtask

  task automatic write_reg(prj_pkg::cfg_index_t idx, logic [23:0] val);
    cfg_write <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    case (idx)
      prj_pkg::CFG_FOCAL_U:  board.fu = val;
      prj_pkg::CFG_FOCAL_V:  board.fv = val;
      prj_pkg::CFG_CENTER_U: board.cu = val;
      prj_pkg::CFG_CENTER_V: board.cv = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() > 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  // Mostly moderate depths so results stay in range; some raw random words.
  task automatic random_point();
    logic signed [31:0] x, y, z;
    int k;
    k = $urandom_range(9);
    x = $urandom; y = $urandom; z = $urandom;
    if (k < 6) begin
      x = $signed(x) >>> $urandom_range(12);
      y = $signed(y) >>> $urandom_range(12);
      z = $signed(z) >>> $urandom_range(14);
    end else if (k == 6) begin
      z = $signed($urandom_range(7)) - 3;
    end
    send_point(x, y, z, 24'($urandom), 24'($urandom));
  endtask

  task automatic run_random(int n);
    repeat (n) random_point();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    send_idle = 38; recv_idle = 75;

    // Directed: zero depth, extremes, sign combinations, saturation.
    send_point(0, 0, 0, 24'sd0, 24'sd0);
    send_point(32'sh7fffffff, 32'sh80000000, 0, 24'sh7fffff, 24'sh800000);
    send_point(32'sh00010000, 32'sh00010000, 32'sh00010000, 24'sd0, 24'sd0);
    send_point(-32'sh00020000, 32'sh00030000, -32'sh00010000, 24'sh000100, -24'sh000100);
    send_point(32'sh7fffffff, 32'sh7fffffff, 1, 24'sh7fffff, 24'sh7fffff);
    send_point(32'sh80000000, 32'sh80000000, -1, 24'sh800000, 24'sh800000);
    send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 24'sd0, 24'sd0);
    send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 24'sh7fffff, 24'sh800000);
    send_point(1, -1, 2, 24'sd0, 24'sd0);
    send_point(3, -3, 2, 24'sd0, 24'sd0);
    send_point(-1, -1, -1, -24'sd1, -24'sd1);
    drain();
    write_reg(prj_pkg::CFG_FOCAL_U, 24'hffffff);
    write_reg(prj_pkg::CFG_FOCAL_V, 24'hffffff);
    write_reg(prj_pkg::CFG_CENTER_U, 24'hffffff);
    write_reg(prj_pkg::CFG_CENTER_V, 24'hffffff);
    send_point(32'sh7fffffff, 32'sh80000000, 1, 24'sh800000, 24'sh7fffff);
    send_point(32'sh00010000, 32'sh00010000, 32'sh00010000, 24'sd0, 24'sd0);
    send_point(5, 5, 32'sh7fffffff, 24'sd0, 24'sd0);
    run_random(300);
    drain();

    write_reg(prj_pkg::CFG_FOCAL_U, 24'd0);
    write_reg(prj_pkg::CFG_FOCAL_V, 24'd0);
    write_reg(prj_pkg::CFG_CENTER_U, 24'd0);
    write_reg(prj_pkg::CFG_CENTER_V, 24'd0);
    send_idle = 75; recv_idle = 38;
    run_random(200);
    drain();

    write_reg(prj_pkg::CFG_FOCAL_U, 24'h01f400);
    write_reg(prj_pkg::CFG_FOCAL_V, 24'h01e000);
    write_reg(prj_pkg::CFG_CENTER_U, 24'h014000);
    write_reg(prj_pkg::CFG_CENTER_V, 24'h00f000);
    send_idle = 0; recv_idle = 0;
    hold_off = 150;
    run_random(350);
    drain();

    write_reg(prj_pkg::CFG_FOCAL_U, 24'($urandom));
    write_reg(prj_pkg::CFG_FOCAL_V, 24'($urandom));
    write_reg(prj_pkg::CFG_CENTER_U, 24'($urandom));
    write_reg(prj_pkg::CFG_CENTER_V, 24'($urandom));
    run_random(330);
    drain();

    $display("Checked %0d result words across five camera settings, zero depth and",
             board.checked);
    $display("saturation cases, random stalls on both sides and a long output hold-off.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("** pinhole_reprojection_error_jacobian: PASSED **");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("** pinhole_reprojection_error_jacobian: FAILED **");
    end
    $finish;
  end

endmodule
